@@ rtl/core/mid_square_random_generator_assert.svh @@
`ifndef MID_SQUARE_RANDOM_GENERATOR_ASSERT_SVH
`define MID_SQUARE_RANDOM_GENERATOR_ASSERT_SVH

// same-cycle implication
`define MSRG_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("msrg assertion failed");

// next-cycle implication
`define MSRG_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("msrg assertion failed");

`endif

@@ rtl/core/msrg_pkg.sv @@
package msrg_pkg;

   localparam int SEED_W     = 27;
   localparam int SQ_W       = 2 * SEED_W;
   localparam int SQ_DIGITS  = 17;            // decimal digits of a SQ_W-bit value
   localparam int BCD_W      = 4 * SQ_DIGITS;
   localparam int DIG_W      = 4;
   localparam int ACC_W      = 30;            // holds 10^9 - 1
   localparam int TOT_W      = $clog2(SQ_DIGITS + 1);
   localparam int MCNT_W     = $clog2(SEED_W + 1);
   localparam int DCNT_W     = $clog2(SQ_W + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [SEED_W-1:0] seed_type;
   typedef logic [SQ_W-1:0]   square_type;
   typedef logic [BCD_W-1:0]  bcd_type;
   typedef logic [DIG_W-1:0]  digit_type;
   typedef logic [ACC_W-1:0]  acc_type;

endpackage

@@ rtl/core/msrg_if.sv @@
interface msrg_req_if;
   logic valid;
   logic ready;
   logic reload;

   modport source (output valid, output reload, input ready);
   modport sink (input valid, input reload, output ready);
endinterface

interface msrg_rsp_if;
   logic               valid;
   logic               ready;
   msrg_pkg::seed_type random_value;

   modport source (output valid, output random_value, input ready);
   modport sink (input valid, input random_value, output ready);
endinterface

@@ rtl/core/msrg_mult.sv @@
// Shift-and-add squarer, one multiplier bit per cycle.
module msrg_mult (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  msrg_pkg::seed_type   seed,
   output logic                 done,
   output msrg_pkg::square_type square
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [msrg_pkg::MCNT_W-1:0] cnt_ff;
   msrg_pkg::seed_type          mcand_ff;
   msrg_pkg::square_type        prod_ff;

   logic [msrg_pkg::SEED_W:0]   sum;
   msrg_pkg::square_type        prod_in;
   logic                        last;

   assign sum = {1'b0, prod_ff[msrg_pkg::SQ_W-1:msrg_pkg::SEED_W]}
              + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign prod_in = {sum, prod_ff[msrg_pkg::SEED_W-1:1]};
   assign last = (cnt_ff == msrg_pkg::MCNT_W'(msrg_pkg::SEED_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= seed;
         prod_ff  <= {{msrg_pkg::SEED_W{1'b0}}, seed};
         cnt_ff   <= '0;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   assign done   = done_ff;
   assign square = prod_ff;

endmodule

@@ rtl/core/msrg_dabble.sv @@
// Binary to BCD, one input bit per cycle (shift-add-3).
module msrg_dabble (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  msrg_pkg::square_type bin,
   output logic                 done,
   output msrg_pkg::bcd_type    bcd
);

   logic                        busy_ff;
   logic                        done_ff;
   logic [msrg_pkg::DCNT_W-1:0] cnt_ff;
   msrg_pkg::square_type        bin_ff;
   msrg_pkg::bcd_type           bcd_ff;

   msrg_pkg::bcd_type           adj;
   logic                        last;

   always_comb begin
      for (int i = 0; i < msrg_pkg::SQ_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                   : bcd_ff[4*i +: 4];
      end
   end

   assign last = (cnt_ff == msrg_pkg::DCNT_W'(msrg_pkg::SQ_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= bin;
         bcd_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         bcd_ff <= {adj[msrg_pkg::BCD_W-2:0], bin_ff[msrg_pkg::SQ_W-1]};
         bin_ff <= {bin_ff[msrg_pkg::SQ_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

@@ rtl/core/msrg_extract.sv @@
// Picks the middle digits: digit shift right to drop the low digits,
// then Horner accumulation MSB digit first, one digit per cycle.
module msrg_extract #(
   parameter int MAX_DIGITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  msrg_pkg::bcd_type   bcd,
   input  msrg_pkg::digit_type kept,
   output logic                done,
   output msrg_pkg::seed_type  value
);

   typedef enum logic [1:0] {X_IDLE, X_ALIGN, X_HORNER} phase_type;

   phase_type                   phase_ff;
   logic                        done_ff;
   msrg_pkg::bcd_type           bcd_ff;
   msrg_pkg::digit_type         shift_ff;
   msrg_pkg::digit_type         pos_ff;
   msrg_pkg::digit_type         kept_ff;
   msrg_pkg::acc_type           acc_ff;

   logic [msrg_pkg::TOT_W-1:0]  total;
   logic [msrg_pkg::TOT_W-1:0]  half_total;
   logic [msrg_pkg::TOT_W-1:0]  half_kept;
   msrg_pkg::digit_type         drop;
   msrg_pkg::digit_type         top_digit;
   msrg_pkg::digit_type         use_digit;
   msrg_pkg::acc_type           acc_in;

   // digit count of the square: position of the highest nonzero digit
   always_comb begin
      total = '0;
      for (int i = 0; i < msrg_pkg::SQ_DIGITS; i++) begin
         if (bcd[4*i +: 4] != 4'd0) begin
            total = msrg_pkg::TOT_W'(i + 1);
         end
      end
   end

   assign half_total = total >> 1;
   assign half_kept  = msrg_pkg::TOT_W'(kept >> 1);
   // negative start clamps to zero
   assign drop = (half_total > half_kept) ? msrg_pkg::DIG_W'(half_total - half_kept) : '0;

   assign top_digit = bcd_ff[4*(MAX_DIGITS-1) +: 4];
   assign use_digit = (pos_ff < kept_ff) ? top_digit : '0;
   assign acc_in    = (acc_ff << 3) + (acc_ff << 1) + msrg_pkg::ACC_W'(use_digit);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= X_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            X_IDLE: begin
               if (start) begin
                  phase_ff <= X_ALIGN;
               end
            end
            X_ALIGN: begin
               if (shift_ff == '0) begin
                  phase_ff <= X_HORNER;
               end
            end
            X_HORNER: begin
               if (pos_ff == '0) begin
                  phase_ff <= X_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: phase_ff <= X_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         bcd_ff   <= bcd;
         shift_ff <= drop;
         kept_ff  <= kept;
         pos_ff   <= msrg_pkg::DIG_W'(MAX_DIGITS - 1);
         acc_ff   <= '0;
      end else if (phase_ff == X_ALIGN && shift_ff != '0) begin
         bcd_ff   <= bcd_ff >> 4;
         shift_ff <= shift_ff - 1'b1;
      end else if (phase_ff == X_HORNER) begin
         acc_ff <= acc_in;
         bcd_ff <= bcd_ff << 4;
         if (pos_ff != '0) begin
            pos_ff <= pos_ff - 1'b1;
         end
      end
   end

   assign done  = done_ff;
   assign value = acc_ff[msrg_pkg::SEED_W-1:0];

endmodule

@@ rtl/core/mid_square_random_generator.sv @@
// Flow: a 27-step squarer, a 54-step binary-to-BCD shifter, then a digit shift that drops
// s low digits (0..8) and a Horner pass over MAX_DIGITS digits.
// One transaction in flight; the next request is taken the cycle after the result is
// registered, even while that result waits on rsp.
// Reset (synchronous): seed 0, initial_seed 0, digit_count 4, no result pending.
module mid_square_random_generator #(
   parameter int MAX_DIGITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   msrg_req_if.sink                            req,
   msrg_rsp_if.source                          rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [msrg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [msrg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [msrg_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam logic REG_INITIAL_SEED = 1'b0;
   localparam logic REG_DIGIT_COUNT  = 1'b1;

   typedef enum logic [2:0] {S_IDLE, S_MUL, S_DAB, S_EXT, S_OUT} state_type;

   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   msrg_pkg::seed_type   rsp_data_ff, rsp_data_in;
   msrg_pkg::seed_type   seed_ff, seed_in;
   msrg_pkg::seed_type   work_ff, work_in;
   logic                 mul_start_ff, mul_start_in;
   logic                 dab_start_ff, dab_start_in;
   logic                 ext_start_ff, ext_start_in;

   msrg_pkg::seed_type   csr_init_ff;
   msrg_pkg::digit_type  csr_dc_ff;
   msrg_pkg::digit_type  kept;
   logic                 csr_wr;

   logic                 mul_done;
   msrg_pkg::square_type square;
   logic                 dab_done;
   msrg_pkg::bcd_type    bcd;
   logic                 ext_done;
   msrg_pkg::seed_type   ext_value;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_init_ff <= '0;
         csr_dc_ff   <= msrg_pkg::DIG_W'(4);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_INITIAL_SEED: csr_init_ff <= csr_pwdata[msrg_pkg::SEED_W-1:0];
            REG_DIGIT_COUNT:  csr_dc_ff   <= csr_pwdata[msrg_pkg::DIG_W-1:0];
            default:          csr_init_ff <= csr_init_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_INITIAL_SEED: csr_prdata = msrg_pkg::CSR_DATA_W'(csr_init_ff);
         REG_DIGIT_COUNT:  csr_prdata = msrg_pkg::CSR_DATA_W'(csr_dc_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign kept = (csr_dc_ff > msrg_pkg::DIG_W'(MAX_DIGITS)) ? msrg_pkg::DIG_W'(MAX_DIGITS)
                                                            : csr_dc_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      seed_in      = seed_ff;
      work_in      = work_ff;
      mul_start_in = 1'b0;
      dab_start_in = 1'b0;
      ext_start_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               work_in      = req.reload ? csr_init_ff : seed_ff;
               mul_start_in = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               dab_start_in = 1'b1;
               state_in     = S_DAB;
            end
         end
         S_DAB: begin
            if (dab_done) begin
               ext_start_in = 1'b1;
               state_in     = S_EXT;
            end
         end
         S_EXT: begin
            if (ext_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ext_value;
               seed_in      = ext_value;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
         mul_start_ff <= 1'b0;
         dab_start_ff <= 1'b0;
         ext_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
         mul_start_ff <= mul_start_in;
         dab_start_ff <= dab_start_in;
         ext_start_ff <= ext_start_in;
      end
      rsp_data_ff <= rsp_data_in;
      work_ff     <= work_in;
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.random_value = rsp_data_ff;

   msrg_mult u_mult (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start_ff),
      .seed   (work_ff),
      .done   (mul_done),
      .square (square)
   );

   msrg_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (dab_start_ff),
      .bin   (square),
      .done  (dab_done),
      .bcd   (bcd)
   );

   msrg_extract #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_extract (
      .clock (clock),
      .reset (reset),
      .start (ext_start_ff),
      .bcd   (bcd),
      .kept  (kept),
      .done  (ext_done),
      .value (ext_value)
   );

`include "mid_square_random_generator_assert.svh"

   `MSRG_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req.valid && req.ready, !req.ready)
   `MSRG_ASSERT_IMPLY(a_single_done, clock, reset, 1'b1, $onehot0({mul_done, dab_done, ext_done}))
   `MSRG_ASSERT_NEXT(a_result_posted, clock, reset, ext_done, state_ff == S_OUT)

endmodule
